// ----- sv/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared request type, operation codes, result status codes and back-end
// sequencer states.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned ItemWidth = 32;
  localparam int unsigned PrioWidth = 8;
  localparam int unsigned FillWidth = 5;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_PUSHED = 2'd0,
    STAT_POPPED = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_SHIFT
  } bk_state_t;

  typedef struct packed {
    op_t                  op;
    logic [ItemWidth-1:0] value;
    logic [PrioWidth-1:0] prio;
  } req_t;

endpackage

// ----- sv/stable_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue unit
// Bounded priority queue that pops the most urgent entry, oldest first among
// equal priorities.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue whenever busy is low; busy rises only when
// that queue is full. Each request yields exactly one result, strobed by done
// for one cycle, and the receiver must take it. The back end can take one push
// per cycle while it is not serving a pop. A pop searches the store for the
// lowest priority value, oldest first among ties, one entry at a time through
// its single registered read port, then moves each later entry down by one to
// close the gap. A pop on an empty queue or a push to a full one is answered
// from the idle state without a search.
module stable_priority_queue_unit #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            kind,
  input  logic [spq_pkg::ItemWidth-1:0]   item_value,
  input  logic [spq_pkg::PrioWidth-1:0]   item_priority,
  output logic                            done,
  output logic [spq_pkg::ItemWidth-1:0]   out_value,
  output logic [1:0]                      status,
  output logic [spq_pkg::FillWidth-1:0]   fill_count
);
  import spq_pkg::*;

  logic q_valid;
  req_t q_req;
  logic q_take;

  spq_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .item_value    (item_value),
    .item_priority (item_priority),
    .q_valid       (q_valid),
    .q_req         (q_req),
    .q_take        (q_take)
  );

  spq_back #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_req      (q_req),
    .q_take     (q_take),
    .done       (done),
    .out_value  (out_value),
    .status     (status),
    .fill_count (fill_count)
  );

`ifndef ASSERT_OFF
  a_nopop_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != STAT_POPPED) |-> out_value == '0)
    else $error("Non-pop result carries a value.");

  a_empty_fill: assert property (@(posedge clk) disable iff (rst)
    done && (status == STAT_EMPTY) |-> fill_count == '0)
    else $error("Empty pop reported with entries held.");

  a_full_fill: assert property (@(posedge clk) disable iff (rst)
    done && (status == STAT_FULL) |-> fill_count == FillWidth'(DEPTH))
    else $error("Dropped push reported while not full.");
`endif

endmodule

// ----- sv/spq_front.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue front end
// Accepts requests, classifies them by operation and holds them in a short
// queue until the back end takes them.
// ----------------------------------------------------------------------------
module spq_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            kind,
  input  logic [spq_pkg::ItemWidth-1:0]   item_value,
  input  logic [spq_pkg::PrioWidth-1:0]   item_priority,
  output logic                            q_valid,
  output spq_pkg::req_t                   q_req,
  input  logic                            q_take
);
  import spq_pkg::*;

  localparam int unsigned PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned NW = $clog2(QueueDepth + 1);

  req_t           slots [QueueDepth];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [NW-1:0]  count;
  logic           push;
  req_t           incoming;

  assign busy     = (count == NW'(QueueDepth));
  assign push     = start && !busy;
  assign q_valid  = (count != '0);
  assign q_req    = slots[rd_ptr];

  always_comb begin
    incoming.op    = kind ? OP_POP : OP_PUSH;
    incoming.value = item_value;
    incoming.prio  = item_priority;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QueueDepth - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (q_take) begin
        rd_ptr <= (rd_ptr == PW'(QueueDepth - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !q_take) begin
        count <= count + NW'(1);
      end else if (!push && q_take) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

// ----- sv/spq_back.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue back end
// Carries out push and pop requests on the entry store, searching for the
// most urgent entry and closing the gap one entry per cycle.
// ----------------------------------------------------------------------------
module spq_back #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  spq_pkg::req_t                   q_req,
  output logic                            q_take,
  output logic                            done,
  output logic [spq_pkg::ItemWidth-1:0]   out_value,
  output logic [1:0]                      status,
  output logic [spq_pkg::FillWidth-1:0]   fill_count
);
  import spq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [PrioWidth-1:0]   prio_mem [DEPTH];
  logic [VALUE_WIDTH-1:0] val_mem  [DEPTH];

  bk_state_t              state;
  bk_state_t              state_next;
  logic [CW-1:0]          cnt;
  logic [CW-1:0]          cnt_next;
  logic [CW-1:0]          ra;
  logic [CW-1:0]          ra_next;
  logic [CW-1:0]          wp;
  logic [CW-1:0]          wp_next;
  logic                   pend;
  logic                   pend_next;
  logic [CW-1:0]          best;
  logic [CW-1:0]          best_next;
  logic [PrioWidth-1:0]   best_prio;
  logic [PrioWidth-1:0]   best_prio_next;
  logic [VALUE_WIDTH-1:0] best_val;
  logic [VALUE_WIDTH-1:0] best_val_next;

  logic [AW-1:0]          rd_addr;
  logic [PrioWidth-1:0]   rd_prio;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [PrioWidth-1:0]   wr_prio;
  logic [VALUE_WIDTH-1:0] wr_val;

  logic                   res_valid_next;
  status_t                res_status_next;
  logic [VALUE_WIDTH-1:0] res_value_next;
  logic                   sel;
  logic [CW-1:0]          wp_eff;
  logic [CW-1:0]          src;

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    ra_next         = ra;
    wp_next         = wp;
    pend_next       = pend;
    best_next       = best;
    best_prio_next  = best_prio;
    best_val_next   = best_val;
    q_take          = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_prio         = rd_prio;
    wr_val          = rd_val;
    res_valid_next  = 1'b0;
    res_status_next = STAT_PUSHED;
    res_value_next  = '0;
    sel             = 1'b0;
    wp_eff          = pend ? wp + CW'(1) : wp;
    src             = wp_eff + CW'(1);

    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          case (q_req.op)
            OP_PUSH: begin
              res_valid_next = 1'b1;
              if (cnt == CW'(DEPTH)) begin
                res_status_next = STAT_FULL;
              end else begin
                wr_en           = 1'b1;
                wr_addr         = cnt[AW-1:0];
                wr_prio         = q_req.prio;
                wr_val          = VALUE_WIDTH'(q_req.value);
                cnt_next        = cnt + CW'(1);
                res_status_next = STAT_PUSHED;
              end
            end
            OP_POP: begin
              if (cnt == '0) begin
                res_valid_next  = 1'b1;
                res_status_next = STAT_EMPTY;
              end else begin
                rd_addr    = '0;
                ra_next    = CW'(1);
                state_next = BK_SCAN;
              end
            end
            default: begin
              res_valid_next = 1'b0;
            end
          endcase
        end
      end
      BK_SCAN: begin
        sel = (ra == CW'(1)) || (rd_prio < best_prio);
        if (sel) begin
          best_next      = ra - CW'(1);
          best_prio_next = rd_prio;
          best_val_next  = rd_val;
        end
        if (ra == cnt) begin
          wp_next    = sel ? ra - CW'(1) : best;
          pend_next  = 1'b0;
          state_next = BK_SHIFT;
        end else begin
          rd_addr = ra[AW-1:0];
          ra_next = ra + CW'(1);
        end
      end
      BK_SHIFT: begin
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = wp[AW-1:0];
          wp_next = wp + CW'(1);
        end
        if (src < cnt) begin
          rd_addr   = src[AW-1:0];
          pend_next = 1'b1;
        end else begin
          pend_next       = 1'b0;
          cnt_next        = cnt - CW'(1);
          res_valid_next  = 1'b1;
          res_status_next = STAT_POPPED;
          res_value_next  = best_val;
          state_next      = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prio_mem[wr_addr] <= wr_prio;
      val_mem[wr_addr]  <= wr_val;
    end
    rd_prio <= prio_mem[rd_addr];
    rd_val  <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
      done  <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ra         <= ra_next;
    wp         <= wp_next;
    best       <= best_next;
    best_prio  <= best_prio_next;
    best_val   <= best_val_next;
    out_value  <= ItemWidth'(res_value_next);
    status     <= res_status_next;
    fill_count <= FillWidth'(cnt_next);
  end

endmodule

// ----- dv/spq_checker.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue checker
// Watches the request and result channels of the queue. It keeps its own
// copy of the queue contents, works out the result of every accepted
// request, and compares each strobed result with the oldest one awaited.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          kind,
  input  logic [spq_pkg::ItemWidth-1:0] item_value,
  input  logic [spq_pkg::PrioWidth-1:0] item_priority,
  input  logic                          done,
  input  logic [spq_pkg::ItemWidth-1:0] out_value,
  input  logic [1:0]                    status,
  input  logic [spq_pkg::FillWidth-1:0] fill_count,
  output int                            mismatch_count,
  output int                            results_awaited
);
  import spq_pkg::*;

  typedef struct {
    logic [ItemWidth-1:0] value;
    status_t              stat;
    logic [FillWidth-1:0] fill;
  } queue_result_t;

  logic [ItemWidth-1:0] held_value [DEPTH];
  logic [PrioWidth-1:0] held_prio  [DEPTH];
  int unsigned          held_count;
  queue_result_t        awaited_results [$];
  int                   mismatch_total;

  assign mismatch_count = mismatch_total;

  task automatic flag_mismatch(string what, logic [ItemWidth-1:0] got,
                               logic [ItemWidth-1:0] want);
    mismatch_total++;
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
  endtask

  function automatic queue_result_t serve_request(op_t op, logic [ItemWidth-1:0] value,
                                                  logic [PrioWidth-1:0] prio);
    queue_result_t res;
    int unsigned   winner;
    res.value = '0;
    if (op == OP_PUSH) begin
      if (held_count >= DEPTH) begin
        res.stat = STAT_FULL;
      end else begin
        held_value[held_count] = value;
        held_prio[held_count]  = prio;
        held_count++;
        res.stat = STAT_PUSHED;
      end
    end else if (held_count == 0) begin
      res.stat = STAT_EMPTY;
    end else begin
      // Strict comparison keeps the oldest entry among equal priorities.
      winner = 0;
      for (int unsigned k = 1; k < held_count; k++) begin
        if (held_prio[k] < held_prio[winner]) begin
          winner = k;
        end
      end
      res.value = held_value[winner];
      for (int unsigned k = winner; k + 1 < held_count; k++) begin
        held_value[k] = held_value[k+1];
        held_prio[k]  = held_prio[k+1];
      end
      held_count--;
      res.stat = STAT_POPPED;
    end
    res.fill = held_count[FillWidth-1:0];
    return res;
  endfunction

  initial begin
    mismatch_total  = 0;
    results_awaited = 0;
    held_count      = 0;
  end

  always @(posedge clk) begin
    queue_result_t want;
    if (rst) begin
      held_count = 0;
      awaited_results.delete();
    end else begin
      if (done) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch("result with no request outstanding, out_value", out_value, '0);
        end else begin
          want = awaited_results.pop_front();
          if (out_value !== want.value) begin
            flag_mismatch("out_value", out_value, want.value);
          end
          if (status !== want.stat) begin
            flag_mismatch("status", ItemWidth'(status), ItemWidth'(want.stat));
          end
          if (fill_count !== want.fill) begin
            flag_mismatch("fill_count", ItemWidth'(fill_count), ItemWidth'(want.fill));
          end
        end
      end
      if (start && !busy) begin
        awaited_results.push_back(serve_request(op_t'(kind), item_value, item_priority));
      end
    end
    results_awaited <= awaited_results.size();
  end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue testbench
// Drives push and pop requests into the queue, first a directed set that
// covers the empty and full cases, priority extremes and ties, then random
// phases that swing the fill level between empty and full with idle bursts.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import spq_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int          RANDOM_REQS = 1100;
  localparam int          QUIET_TAIL  = 150;
  localparam int          STALL_LIMIT = 4000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 kind;
  logic [ItemWidth-1:0] item_value;
  logic [PrioWidth-1:0] item_priority;
  logic                 done;
  logic [ItemWidth-1:0] out_value;
  logic [1:0]           status;
  logic [FillWidth-1:0] fill_count;
  int                   mismatch_count;
  int                   results_awaited;
  int                   stall_cycles;

  stable_priority_queue_unit #(
    .DEPTH(DEPTH),
    .VALUE_WIDTH(ItemWidth)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .item_value(item_value),
    .item_priority(item_priority),
    .done(done),
    .out_value(out_value),
    .status(status),
    .fill_count(fill_count)
  );

  spq_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .item_value(item_value),
    .item_priority(item_priority),
    .done(done),
    .out_value(out_value),
    .status(status),
    .fill_count(fill_count),
    .mismatch_count(mismatch_count),
    .results_awaited(results_awaited)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The run is ended if neither a request nor a result moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic issue_request(op_t op, logic [ItemWidth-1:0] value,
                               logic [PrioWidth-1:0] prio, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    kind          <= op;
    item_value    <= value;
    item_priority <= prio;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_for_results;
    start <= 1'b0;
    @(posedge clk);
    while (results_awaited != 0) @(posedge clk);
  endtask

  function automatic logic [PrioWidth-1:0] pick_priority();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) begin
      return PrioWidth'($urandom_range(1, 4));
    end else if (roll < 9) begin
      return PrioWidth'($urandom_range(0, 255));
    end
    return ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd1;
  endfunction

  initial begin
    int push_pct;
    int idle_pct;
    int gap;
    clk           = 1'b0;
    rst           = 1'b1;
    start         = 1'b0;
    kind          = 1'b0;
    item_value    = '0;
    item_priority = '0;
    stall_cycles  = 0;
    push_pct      = 50;
    idle_pct      = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty pop, extremes, ties, fill to full, dropped push.
    issue_request(OP_POP, $urandom, PrioWidth'($urandom), 0);
    issue_request(OP_PUSH, 32'hFFFF_FFFF, 8'd255, 0);
    issue_request(OP_PUSH, 32'h0000_0000, 8'd1, 0);
    issue_request(OP_PUSH, 32'h1111_1111, 8'd7, 0);
    issue_request(OP_PUSH, 32'h2222_2222, 8'd7, 0);
    issue_request(OP_PUSH, 32'h3333_3333, 8'd7, 0);
    issue_request(OP_PUSH, 32'hA5A5_A5A5, 8'd0, 0);
    for (int i = 0; i < 10; i++) begin
      issue_request(OP_PUSH, $urandom, PrioWidth'(9 + 20 * i), 0);
    end
    issue_request(OP_PUSH, 32'hDEAD_BEEF, 8'd1, 0);
    repeat (4) issue_request(OP_POP, $urandom, PrioWidth'($urandom), 0);
    wait_for_results();

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 4))
          0: push_pct = 10;
          1: push_pct = 35;
          2: push_pct = 50;
          3: push_pct = 70;
          default: push_pct = 90;
        endcase
        idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
      if (n == RANDOM_REQS / 2) begin
        wait_for_results();
      end
      gap = 0;
      if (n < RANDOM_REQS - QUIET_TAIL && $urandom_range(0, 99) < idle_pct) begin
        gap = $urandom_range(1, 18);
      end
      if ($urandom_range(0, 99) < push_pct) begin
        issue_request(OP_PUSH, $urandom, pick_priority(), gap);
      end else begin
        issue_request(OP_POP, $urandom, PrioWidth'($urandom), gap);
      end
    end

    wait_for_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/spq_pkg.sv
sv/spq_front.sv
sv/spq_back.sv
sv/stable_priority_queue_unit.sv
dv/spq_checker.sv
dv/tb_top.sv
